>>> design/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// shared command codes, status codes and result flag bundle for the deque
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned WordW   = 32;

  // commands
  localparam logic [CmdW-1:0] CMD_PUSH_REAR  = 3'd0;
  localparam logic [CmdW-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CmdW-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CmdW-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CmdW-1:0] CMD_READ_FRONT = 3'd4;
  localparam logic [CmdW-1:0] CMD_READ_REAR  = 3'd5;

  // status codes
  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;

  // per-beat result info that travels alongside the ram read
  typedef struct packed {
    logic               rd_en;    // result takes the ram read data
    logic [StatusW-1:0] status;
    logic               is_empty;
    logic               is_full;
  } meta_t;

endpackage

`default_nettype wire

>>> design/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// ring storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [AW-1:0]               waddr_i,
  input  wire logic [cdq_pkg::WordW-1:0]   wdata_i,
  input  wire logic                        re_i,
  input  wire logic [AW-1:0]               raddr_i,
  output logic      [cdq_pkg::WordW-1:0]   rdata_o
);

  logic [cdq_pkg::WordW-1:0] mem_q [DEPTH];
  logic [cdq_pkg::WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// head and tail pointers, command decode and ram access generation
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        fire_i,
  input  wire logic [cdq_pkg::CmdW-1:0]    cmd_i,
  output logic                             we_o,
  output logic      [AW-1:0]               waddr_o,
  output logic                             re_o,
  output logic      [AW-1:0]               raddr_o,
  output cdq_pkg::meta_t                   meta_o
);

  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic          empty, full;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [cdq_pkg::StatusW-1:0] status;

  assign head_inc = head_q + AW'(1);
  assign head_dec = head_q - AW'(1);
  assign tail_inc = tail_q + AW'(1);
  assign tail_dec = tail_q - AW'(1);

  assign empty = (head_q == tail_q);
  assign full  = (tail_inc == head_q);

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    we     = 1'b0;
    re     = 1'b0;
    waddr  = tail_inc;
    raddr  = tail_q;
    status = cdq_pkg::ST_OK;
    case (cmd_i)
      cdq_pkg::CMD_PUSH_REAR: begin
        if (full) begin
          status = cdq_pkg::ST_FULL;
        end else begin
          we     = 1'b1;
          waddr  = tail_inc;
          tail_d = tail_inc;
        end
      end
      cdq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          status = cdq_pkg::ST_FULL;
        end else begin
          we     = 1'b1;
          waddr  = head_q;
          head_d = head_dec;
        end
      end
      cdq_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          status = cdq_pkg::ST_EMPTY;
        end else begin
          re     = 1'b1;
          raddr  = head_inc;
          head_d = head_inc;
        end
      end
      cdq_pkg::CMD_POP_REAR: begin
        if (empty) begin
          status = cdq_pkg::ST_EMPTY;
        end else begin
          re     = 1'b1;
          raddr  = tail_q;
          tail_d = tail_dec;
        end
      end
      cdq_pkg::CMD_READ_FRONT: begin
        if (empty) begin
          status = cdq_pkg::ST_EMPTY;
        end else begin
          re    = 1'b1;
          raddr = head_inc;
        end
      end
      cdq_pkg::CMD_READ_REAR: begin
        if (empty) begin
          status = cdq_pkg::ST_EMPTY;
        end else begin
          re    = 1'b1;
          raddr = tail_q;
        end
      end
      default: begin
        // unused codes leave everything alone
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else if (fire_i) begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  assign we_o    = fire_i & we;
  assign re_o    = fire_i & re;
  assign waddr_o = waddr;
  assign raddr_o = raddr;

  // flags as they stand after the step
  assign meta_o.rd_en    = re;
  assign meta_o.status   = status;
  assign meta_o.is_empty = (head_d == tail_d);
  assign meta_o.is_full  = ((tail_d + AW'(1)) == head_d);

endmodule

`default_nettype wire

>>> design/circular_deque_core.sv
// ----------------------------------------------------------------------------
// circular_deque_core
// double-ended queue of 32-bit words in a ring of DEPTH slots (DEPTH-1 usable)
// ----------------------------------------------------------------------------
//
//  port group   dir  tdata fields (lsb first)
//  s_axis_*     in   command[2:0], push_value[34:3], zero pad [39:35]
//  m_axis_*     out  read_value[31:0], status[33:32], is_empty[34],
//                    is_full[35], zero pad [39:36]
//
//  one command per cycle while s_axis_tready_o is high
//  the accept edge decides, moves any pointer and issues at most one ram access;
//  the registered ram read sets the first stage, then an output
//  register holds the beat for the consumer
//  a push writes at its accept edge, so any later pop/read sees the word
//  reset clears head and tail pointers and the valid bits; ram is not cleared
//  when the output stalls the two stages fill, then s_axis_tready_o drops
//
`default_nettype none

module circular_deque_core #(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // command beats
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,   // command[2:0], push_value[34:3]
  // result beats
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [39:0] m_axis_tdata_o    // read_value, status, is_empty, is_full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // input unpacking
  logic [cdq_pkg::CmdW-1:0]  cmd;
  logic [cdq_pkg::WordW-1:0] push_value;

  assign cmd        = s_axis_tdata_i[2:0];
  assign push_value = s_axis_tdata_i[34:3];

  // control / ram wiring
  logic                      fire;
  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [cdq_pkg::WordW-1:0] ram_rdata;
  cdq_pkg::meta_t            meta;

  // stage 1: ram read in flight
  logic           s1_valid_q;
  cdq_pkg::meta_t s1_meta_q;
  logic           s1_adv;

  // output register
  logic                        o_valid_q;
  logic [cdq_pkg::WordW-1:0]   o_rd_q;
  cdq_pkg::meta_t              o_meta_q;

  assign s1_adv          = s1_valid_q & (~o_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~s1_valid_q | s1_adv;
  assign fire            = s_axis_tvalid_i & s_axis_tready_o;

  cdq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .cmd_i   (cmd),
    .we_o    (ram_we),
    .waddr_o (ram_waddr),
    .re_o    (ram_re),
    .raddr_o (ram_raddr),
    .meta_o  (meta)
  );

  cdq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (push_value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      if (fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        o_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // payload; ram read data only changes on a new accepted read, so it holds
  // while stage 1 waits
  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_meta_q <= meta;
    end
    if (s1_adv) begin
      o_meta_q <= s1_meta_q;
      o_rd_q   <= s1_meta_q.rd_en ? ram_rdata : '0;
    end
  end

  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tdata_o  = {4'b0000, o_meta_q.is_full, o_meta_q.is_empty,
                            o_meta_q.status, o_rd_q};

endmodule

`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for circular_deque_core: a command table, then biased
// random fill/drain traffic, with results checked beat by beat against table rows or a ring model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;

  localparam int unsigned DEPTH      = 128;
  localparam int unsigned IdxW       = $clog2(DEPTH);
  localparam int          RandItems  = 1300;
  localparam int          PressureAt = 1150;   // beat count where the long stall starts
  localparam int          HoldCycles = 400;
  localparam int          SettleCyc  = 8;      // result passes stage 1 and the output register after its beat
  localparam int          CycleLimit = 200000;

  // codes the block must ignore
  localparam logic [cdq_pkg::CmdW-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [cdq_pkg::CmdW-1:0] CMD_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [cdq_pkg::WordW-1:0]   read_value;
    logic [cdq_pkg::StatusW-1:0] status;
    logic                        is_empty;
    logic                        is_full;
  } deque_result_t;

  typedef struct {
    logic [cdq_pkg::CmdW-1:0]  cmd;
    logic [cdq_pkg::WordW-1:0] value;     // first value; repeated rows count up from it
    int                        reps;
    bit                        fixed;     // compare against want instead of the ring model
    deque_result_t             want;
  } cmd_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;   // command[2:0], push_value[34:3], zero pad
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;        // read_value[31:0], status, is_empty, is_full

  // ring model state
  logic [IdxW-1:0]           ring_head;
  logic [IdxW-1:0]           ring_tail;
  logic [cdq_pkg::WordW-1:0] ring_words [DEPTH];

  deque_result_t awaited_results [$];
  int            error_count = 0;
  int            beat_count = 0;
  int            cycle_count = 0;
  int            send_idle_pct = 20;
  int            recv_idle_pct = 47;
  bit            held_off = 1'b0;

  // directed commands, starting from the empty deque after reset
  cmd_row_t cmd_table [$] = '{
    '{cdq_pkg::CMD_POP_FRONT,  32'h0000_0000,   1, 1'b1,
      '{32'h0, cdq_pkg::ST_EMPTY, 1'b1, 1'b0}},
    '{cdq_pkg::CMD_POP_REAR,   32'h0000_0000,   1, 1'b1,
      '{32'h0, cdq_pkg::ST_EMPTY, 1'b1, 1'b0}},
    '{cdq_pkg::CMD_READ_FRONT, 32'h0000_0000,   1, 1'b1,
      '{32'h0, cdq_pkg::ST_EMPTY, 1'b1, 1'b0}},
    '{cdq_pkg::CMD_READ_REAR,  32'h0000_0000,   1, 1'b1,
      '{32'h0, cdq_pkg::ST_EMPTY, 1'b1, 1'b0}},
    '{CMD_UNUSED_6,            32'hFFFF_FFFF,   1, 1'b1,
      '{32'h0, cdq_pkg::ST_OK, 1'b1, 1'b0}},
    '{CMD_UNUSED_7,            32'hFFFF_FFFF,   1, 1'b1,
      '{32'h0, cdq_pkg::ST_OK, 1'b1, 1'b0}},
    '{cdq_pkg::CMD_PUSH_REAR,  32'h7FFF_FFFF,   1, 1'b1,
      '{32'h0, cdq_pkg::ST_OK, 1'b0, 1'b0}},
    '{cdq_pkg::CMD_PUSH_FRONT, 32'h8000_0000,   1, 1'b1,
      '{32'h0, cdq_pkg::ST_OK, 1'b0, 1'b0}},
    '{cdq_pkg::CMD_READ_FRONT, 32'h0000_0000,   1, 1'b1,
      '{32'h8000_0000, cdq_pkg::ST_OK, 1'b0, 1'b0}},
    '{cdq_pkg::CMD_READ_REAR,  32'h0000_0000,   1, 1'b1,
      '{32'h7FFF_FFFF, cdq_pkg::ST_OK, 1'b0, 1'b0}},
    '{cdq_pkg::CMD_POP_REAR,   32'h0000_0000,   1, 1'b1,
      '{32'h7FFF_FFFF, cdq_pkg::ST_OK, 1'b0, 1'b0}},
    '{cdq_pkg::CMD_POP_FRONT,  32'h0000_0000,   1, 1'b1,
      '{32'h8000_0000, cdq_pkg::ST_OK, 1'b1, 1'b0}},
    // front push then rear pop of the same slot, pointers wrap below zero
    '{cdq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF,   1, 1'b1,
      '{32'h0, cdq_pkg::ST_OK, 1'b0, 1'b0}},
    '{cdq_pkg::CMD_POP_REAR,   32'h0000_0000,   1, 1'b1,
      '{32'hFFFF_FFFF, cdq_pkg::ST_OK, 1'b1, 1'b0}},
    '{cdq_pkg::CMD_PUSH_REAR,  32'h0000_0000,   1, 1'b1,
      '{32'h0, cdq_pkg::ST_OK, 1'b0, 1'b0}},
    '{cdq_pkg::CMD_POP_FRONT,  32'h0000_0000,   1, 1'b1,
      '{32'h0, cdq_pkg::ST_OK, 1'b1, 1'b0}},
    // fill to one short of full, then the last slot from the front
    '{cdq_pkg::CMD_PUSH_REAR,  32'h0000_0001, 126, 1'b0,
      '{32'h0, cdq_pkg::ST_OK, 1'b0, 1'b0}},
    '{cdq_pkg::CMD_PUSH_FRONT, 32'h5555_5555,   1, 1'b1,
      '{32'h0, cdq_pkg::ST_OK, 1'b0, 1'b1}},
    '{cdq_pkg::CMD_PUSH_REAR,  32'h0000_1234,   1, 1'b1,
      '{32'h0, cdq_pkg::ST_FULL, 1'b0, 1'b1}},
    '{cdq_pkg::CMD_PUSH_FRONT, 32'hAAAA_AAAA,   1, 1'b1,
      '{32'h0, cdq_pkg::ST_FULL, 1'b0, 1'b1}},
    '{CMD_UNUSED_6,            32'h0000_0000,   1, 1'b1,
      '{32'h0, cdq_pkg::ST_OK, 1'b0, 1'b1}},
    '{cdq_pkg::CMD_READ_FRONT, 32'h0000_0000,   1, 1'b1,
      '{32'h5555_5555, cdq_pkg::ST_OK, 1'b0, 1'b1}},
    '{cdq_pkg::CMD_POP_FRONT,  32'h0000_0000,   1, 1'b1,
      '{32'h5555_5555, cdq_pkg::ST_OK, 1'b0, 1'b0}},
    // drain from the rear back to empty
    '{cdq_pkg::CMD_POP_REAR,   32'h0000_0000, 126, 1'b0,
      '{32'h0, cdq_pkg::ST_OK, 1'b0, 1'b0}},
    '{cdq_pkg::CMD_READ_REAR,  32'h0000_0000,   1, 1'b1,
      '{32'h0, cdq_pkg::ST_EMPTY, 1'b1, 1'b0}}
  };

  circular_deque_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // one deque command applied to the ring model, returns the beat it should produce
  function automatic deque_result_t deque_step_result(
      input logic [cdq_pkg::CmdW-1:0] cmd,
      input logic [cdq_pkg::WordW-1:0] value);
    deque_result_t   res;
    logic            was_empty;
    logic            was_full;
    res = '0;
    res.status = cdq_pkg::ST_OK;
    was_empty = (ring_head == ring_tail);
    was_full  = (IdxW'(ring_tail + 1'b1) == ring_head);
    case (cmd)
      cdq_pkg::CMD_PUSH_REAR: begin
        if (was_full) begin
          res.status = cdq_pkg::ST_FULL;
        end else begin
          ring_tail = ring_tail + 1'b1;
          ring_words[ring_tail] = value;
        end
      end
      cdq_pkg::CMD_PUSH_FRONT: begin
        if (was_full) begin
          res.status = cdq_pkg::ST_FULL;
        end else begin
          ring_words[ring_head] = value;
          ring_head = ring_head - 1'b1;
        end
      end
      cdq_pkg::CMD_POP_FRONT: begin
        if (was_empty) begin
          res.status = cdq_pkg::ST_EMPTY;
        end else begin
          ring_head = ring_head + 1'b1;
          res.read_value = ring_words[ring_head];
        end
      end
      cdq_pkg::CMD_POP_REAR: begin
        if (was_empty) begin
          res.status = cdq_pkg::ST_EMPTY;
        end else begin
          res.read_value = ring_words[ring_tail];
          ring_tail = ring_tail - 1'b1;
        end
      end
      cdq_pkg::CMD_READ_FRONT: begin
        if (was_empty) res.status = cdq_pkg::ST_EMPTY;
        else res.read_value = ring_words[IdxW'(ring_head + 1'b1)];
      end
      cdq_pkg::CMD_READ_REAR: begin
        if (was_empty) res.status = cdq_pkg::ST_EMPTY;
        else res.read_value = ring_words[ring_tail];
      end
      default: begin
        // unused codes leave everything alone
      end
    endcase
    res.is_empty = (ring_head == ring_tail);
    res.is_full  = (IdxW'(ring_tail + 1'b1) == ring_head);
    return res;
  endfunction

  // offer one command beat, entered and left at a falling edge
  task automatic send_cmd(input logic [cdq_pkg::CmdW-1:0] cmd,
                          input logic [cdq_pkg::WordW-1:0] value,
                          input bit fixed, input deque_result_t want);
    deque_result_t model_res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'b0, value, cmd};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    // beat taken at this edge: model always advances, table rows may override
    model_res = deque_step_result(cmd, value);
    awaited_results.push_back(fixed ? want : model_res);
    beat_count++;
    // idle pattern: sender light/receiver heavy, then swapped, then none
    if (beat_count < 530) begin
      send_idle_pct = 20;
      recv_idle_pct = 47;
    end else if (beat_count < 1060) begin
      send_idle_pct = 47;
      recv_idle_pct = 20;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [cdq_pkg::WordW-1:0] want,
                             input logic [cdq_pkg::WordW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // result beats are compared against the oldest outstanding expectation
  always @(posedge clk_i) begin
    deque_result_t want;
    deque_result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.read_value = m_axis_tdata_o[31:0];
      got.status     = m_axis_tdata_o[33:32];
      got.is_empty   = m_axis_tdata_o[34];
      got.is_full    = m_axis_tdata_o[35];
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("read_value", want.read_value, got.read_value);
        check_field("status", cdq_pkg::WordW'(want.status), cdq_pkg::WordW'(got.status));
        check_field("is_empty", cdq_pkg::WordW'(want.is_empty),
                    cdq_pkg::WordW'(got.is_empty));
        check_field("is_full", cdq_pkg::WordW'(want.is_full),
                    cdq_pkg::WordW'(got.is_full));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("circular_deque_core test failed");
      $finish;
    end
  end

  // result side: random backpressure plus one long hold-off so the pipe fills
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && beat_count >= PressureAt) begin
        held_off = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // command side
  initial begin
    int                        mode;
    int                        seg_left;
    int                        push_pct;
    int                        counted;
    logic [cdq_pkg::CmdW-1:0]  cmd;
    logic [cdq_pkg::WordW-1:0] value;

    ring_head = '0;
    ring_tail = '0;
    foreach (ring_words[i]) ring_words[i] = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (cmd_table[r]) begin
      for (int k = 0; k < cmd_table[r].reps; k++) begin
        send_cmd(cmd_table[r].cmd, cmd_table[r].value + cdq_pkg::WordW'(k),
                 cmd_table[r].fixed, cmd_table[r].want);
      end
    end

    // random segments that lean toward filling, draining, or neither, so the
    // deque swings between empty and full; a few unused codes go in as noise
    counted  = 0;
    seg_left = 0;
    mode     = 0;
    while (counted < RandItems) begin
      if (seg_left == 0) begin
        mode     = $urandom_range(2);
        seg_left = $urandom_range(300, 40);
      end
      seg_left--;
      if ($urandom_range(99) < 3) begin
        cmd = $urandom_range(1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
      end else begin
        push_pct = (mode == 0) ? 75 : (mode == 1) ? 15 : 50;
        if ($urandom_range(99) < push_pct) begin
          cmd = $urandom_range(1) ? cdq_pkg::CMD_PUSH_REAR : cdq_pkg::CMD_PUSH_FRONT;
        end else begin
          case ($urandom_range(3))
            0: cmd = cdq_pkg::CMD_POP_FRONT;
            1: cmd = cdq_pkg::CMD_POP_REAR;
            2: cmd = cdq_pkg::CMD_READ_FRONT;
            default: cmd = cdq_pkg::CMD_READ_REAR;
          endcase
        end
        counted++;
      end
      case ($urandom_range(9))
        0: value = 32'h0000_0000;
        1: value = 32'h7FFF_FFFF;
        2: value = 32'h8000_0000;
        3: value = 32'hFFFF_FFFF;
        default: value = $urandom;
      endcase
      send_cmd(cmd, value, 1'b0, '0);
    end

    s_axis_tvalid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
    if (error_count == 0) begin
      $display("circular_deque_core test passed");
    end else begin
      $display("circular_deque_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
